### sv/ft2d_pkg.sv
package ft2d_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int ANGLE_WIDTH    = 16;
  localparam int ROTATION_STEPS = 16;

  // Extra fraction bits carried through the rotation.
  localparam int GUARD_BITS = 58 - COORD_WIDTH;
  // Vector as formed from the ports, after a possible negation.
  localparam int VEC_W = COORD_WIDTH + 2;
  // Rotation datapath width, with headroom for the gain of the rotation.
  localparam int ROT_W = VEC_W + GUARD_BITS + 2;
  // Residual angle width: 32-bit binary angle plus growth.
  localparam int ZW = 34;
  localparam int TABLE_LEN = 24;

  // Reciprocal of the rotation gain in Q0.31.
  localparam logic [30:0] INV_GAIN = 31'h4DBA76D4;

  // Input register, rotation stages, then six scaling and rounding stages.
  localparam int LATENCY = ROTATION_STEPS + 7;

  typedef enum logic [1:0] {
    KIND_TO_LOCAL = 2'd0,
    KIND_TO_MAP   = 2'd1,
    KIND_POLAR    = 2'd2
  } kind_e;

  typedef struct packed {
    logic                          add_org;
    logic                          zero_out;
    logic signed [COORD_WIDTH-1:0] org_x;
    logic signed [COORD_WIDTH-1:0] org_y;
  } side_t;

  typedef struct packed {
    logic  valid;
    side_t side;
  } ctl_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_val(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### sv/frame_transform_2d_core.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------------
// request   | in        | start_i high, busy_o low | kind_i, point_x/y_i, origin_x/y_i, heading_i
// result    | out       | done_o, one cycle      | out_x_o, out_y_o, overflow_o
//
// One item enters every cycle; busy_o stays low because nothing downstream can stall.
// Each result passes through one input register, one register per rotation step (16),
// and six stages of gain scaling, rounding and saturation. Reset clears only the
// control words of the pipeline; a result is never held, so done_o is a strobe that
// the receiver must take in that cycle.
module frame_transform_2d_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic [1:0]                              kind_i,
  input  logic signed [ft2d_pkg::COORD_WIDTH-1:0] point_x_i,
  input  logic signed [ft2d_pkg::COORD_WIDTH-1:0] point_y_i,
  input  logic signed [ft2d_pkg::COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [ft2d_pkg::COORD_WIDTH-1:0] origin_y_i,
  input  logic [ft2d_pkg::ANGLE_WIDTH-1:0]        heading_i,
  output logic                                    done_o,
  output logic signed [ft2d_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [ft2d_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic                                    overflow_o
);

  localparam int CW = ft2d_pkg::COORD_WIDTH;
  localparam int AW = ft2d_pkg::ANGLE_WIDTH;
  localparam int VW = ft2d_pkg::VEC_W;
  localparam int ZW = ft2d_pkg::ZW;

  localparam logic [AW-1:0]      QUARTER = {2'b01, {(AW-2){1'b0}}};
  localparam logic signed [31:0] QTR32   = 32'sh4000_0000;

  logic                 accept;
  logic [AW-1:0]        ang;
  logic signed [31:0]   a32, z32;
  logic                 far;
  logic signed [CW-1:0] opa_x, opb_x, opa_y, opb_y;
  logic signed [VW-1:0] x0_d, y0_d;
  logic signed [ZW-1:0] z0_d;
  ft2d_pkg::ctl_t       ctl0_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    ang                  = heading_i;
    opa_x                = point_x_i;
    opb_x                = '0;
    opa_y                = point_y_i;
    opb_y                = '0;
    ctl0_d.valid         = accept;
    ctl0_d.side.add_org  = 1'b0;
    ctl0_d.side.zero_out = 1'b0;
    ctl0_d.side.org_x    = origin_x_i;
    ctl0_d.side.org_y    = origin_y_i;
    case (kind_i)
      ft2d_pkg::KIND_TO_LOCAL: begin
        ang   = heading_i - QUARTER;
        opb_x = origin_x_i;
        opb_y = origin_y_i;
      end
      ft2d_pkg::KIND_TO_MAP: begin
        ang                 = heading_i + QUARTER;
        ctl0_d.side.add_org = 1'b1;
      end
      ft2d_pkg::KIND_POLAR: begin
        opa_y = '0;
      end
      default: begin
        ctl0_d.side.zero_out = 1'b1;
      end
    endcase

    // Beyond a quarter turn either way, rotate the negated vector by the angle moved half a turn toward zero.
    a32  = {ang, {(32-AW){1'b0}}};
    far  = (a32 > QTR32) || (a32 < -QTR32);
    z32  = far ? {~a32[31], a32[30:0]} : a32;
    z0_d = ZW'(z32);
    if (far) begin
      x0_d = VW'(opb_x) - VW'(opa_x);
      y0_d = VW'(opb_y) - VW'(opa_y);
    end else begin
      x0_d = VW'(opa_x) - VW'(opb_x);
      y0_d = VW'(opa_y) - VW'(opb_y);
    end
  end

  ft2d_pkg::ctl_t       ctl0_q;
  logic signed [VW-1:0] x0_q, y0_q;
  logic signed [ZW-1:0] z0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      z0_q <= z0_d;
    end
  end

  ft2d_pkg::ctl_t                    rot_ctl;
  logic signed [ft2d_pkg::ROT_W-1:0] rot_x, rot_y;

  ft2d_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl0_q),
    .x_i    (x0_q),
    .y_i    (y0_q),
    .z_i    (z0_q),
    .ctl_o  (rot_ctl),
    .x_o    (rot_x),
    .y_o    (rot_y)
  );

  ft2d_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rot_ctl),
    .x_i        (rot_x),
    .y_i        (rot_y),
    .done_o     (done_o),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .overflow_o (overflow_o)
  );

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  // A result only comes out of an item accepted at the pipeline's input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, ft2d_pkg::LATENCY))
    else $error("result without a matching item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_o |-> done_o)
    else $error("overflow flagged outside a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_o |-> (out_x_o == C_MAX || out_x_o == C_MIN ||
                    out_y_o == C_MAX || out_y_o == C_MIN))
    else $error("overflow flagged on an unsaturated result");

endmodule

### sv/ft2d_cordic.sv
module ft2d_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ft2d_pkg::ctl_t                      ctl_i,
  input  logic signed [ft2d_pkg::VEC_W-1:0]   x_i,
  input  logic signed [ft2d_pkg::VEC_W-1:0]   y_i,
  input  logic signed [ft2d_pkg::ZW-1:0]      z_i,
  output ft2d_pkg::ctl_t                      ctl_o,
  output logic signed [ft2d_pkg::ROT_W-1:0]   x_o,
  output logic signed [ft2d_pkg::ROT_W-1:0]   y_o
);

  localparam int N   = ft2d_pkg::ROTATION_STEPS;
  localparam int RW  = ft2d_pkg::ROT_W;
  localparam int ZW  = ft2d_pkg::ZW;
  localparam int G   = ft2d_pkg::GUARD_BITS;
  localparam int EXT = RW - ft2d_pkg::VEC_W - G;

  logic signed [RW-1:0] x_s, y_s;
  logic signed [RW-1:0] x_q [N];
  logic signed [RW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  ft2d_pkg::ctl_t       ctl_q [N];

  assign x_s = {{EXT{x_i[ft2d_pkg::VEC_W-1]}}, x_i, {G{1'b0}}};
  assign y_s = {{EXT{y_i[ft2d_pkg::VEC_W-1]}}, y_i, {G{1'b0}}};

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [31:0] ANG32 = ft2d_pkg::atan_val(i);
    localparam logic signed [ZW-1:0] ANG = {{(ZW-32){1'b0}}, ANG32};

    logic signed [RW-1:0] x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d;
    ft2d_pkg::ctl_t       ctl_in;

    if (i == 0) begin : g_first
      assign x_in   = x_s;
      assign y_in   = y_s;
      assign z_in   = z_i;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign ctl_in = ctl_q[i-1];
    end

    // Rotate toward a zero residual angle; arithmetic shifts floor.
    always_comb begin
      if (!z_in[ZW-1]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - ANG;
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else begin
        ctl_q[i] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_in.valid) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  assign ctl_o = ctl_q[N-1];
  assign x_o   = x_q[N-1];
  assign y_o   = y_q[N-1];

endmodule

### sv/ft2d_post.sv
module ft2d_post (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ft2d_pkg::ctl_t                         ctl_i,
  input  logic signed [ft2d_pkg::ROT_W-1:0]      x_i,
  input  logic signed [ft2d_pkg::ROT_W-1:0]      y_i,
  output logic                                   done_o,
  output logic signed [ft2d_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [ft2d_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic                                   overflow_o
);

  localparam int RW    = ft2d_pkg::ROT_W;
  localparam int CW    = ft2d_pkg::COORD_WIDTH;
  localparam int G     = ft2d_pkg::GUARD_BITS;
  localparam int MAG_W = RW - 1;
  localparam int HI_W  = MAG_W - 31;
  localparam int PH_W  = HI_W + 31;
  localparam int RES_W = RW + 1 - G;
  localparam int SUM_W = RES_W + 1;

  localparam logic [61:0]     ROUND_Q31 = 62'd1 << 30;
  localparam logic signed [RW:0] HALF_LSB = (RW+1)'(1) <<< (G - 1);

  ft2d_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;

  // Stage 1: sign and magnitude.
  logic [MAG_W-1:0] mag_x_d, mag_y_d, mag_x_q, mag_y_q;
  logic [RW-1:0]    abs_x, abs_y;
  logic             sgn_x1_q, sgn_y1_q;

  always_comb begin
    abs_x   = x_i[RW-1] ? RW'(-x_i) : RW'(x_i);
    abs_y   = y_i[RW-1] ? RW'(-y_i) : RW'(y_i);
    mag_x_d = abs_x[MAG_W-1:0];
    mag_y_d = abs_y[MAG_W-1:0];
  end

  // Stage 2: partial products of the magnitude and the inverse gain.
  logic [PH_W-1:0] ph_x_d, ph_y_d, ph_x2_q, ph_y2_q;
  logic [61:0]     pl_x_d, pl_y_d, pl_x_q, pl_y_q;
  logic            sgn_x2_q, sgn_y2_q;

  always_comb begin
    ph_x_d = {{31{1'b0}}, mag_x_q[MAG_W-1:31]} * {{HI_W{1'b0}}, ft2d_pkg::INV_GAIN};
    ph_y_d = {{31{1'b0}}, mag_y_q[MAG_W-1:31]} * {{HI_W{1'b0}}, ft2d_pkg::INV_GAIN};
    pl_x_d = {31'd0, mag_x_q[30:0]} * {31'd0, ft2d_pkg::INV_GAIN};
    pl_y_d = {31'd0, mag_y_q[30:0]} * {31'd0, ft2d_pkg::INV_GAIN};
  end

  // Stage 3: round the low partial product to Q0.
  logic [61:0]     lsum_x, lsum_y;
  logic [30:0]     lr_x_q, lr_y_q;
  logic [PH_W-1:0] ph_x3_q, ph_y3_q;
  logic            sgn_x3_q, sgn_y3_q;

  assign lsum_x = pl_x_q + ROUND_Q31;
  assign lsum_y = pl_y_q + ROUND_Q31;

  // Stage 4: scaled magnitude.
  logic [RW-1:0] r_x_d, r_y_d, r_x_q, r_y_q;
  logic          sgn_x4_q, sgn_y4_q;

  assign r_x_d = RW'(ph_x3_q) + RW'(lr_x_q);
  assign r_y_d = RW'(ph_y3_q) + RW'(lr_y_q);

  // Stage 5: restore the sign, round and drop the guard bits.
  logic signed [RW:0]      v_x, v_y;
  logic signed [RES_W-1:0] res_x_q, res_y_q;

  always_comb begin
    v_x = sgn_x4_q ? (HALF_LSB - $signed({1'b0, r_x_q})) : ($signed({1'b0, r_x_q}) + HALF_LSB);
    v_y = sgn_y4_q ? (HALF_LSB - $signed({1'b0, r_y_q})) : ($signed({1'b0, r_y_q}) + HALF_LSB);
  end

  // Stage 6: add the origin if requested and saturate, or zero the result for an unused kind.
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [CW-1:0]    sat_x, sat_y, out_x_d, out_y_d;
  logic                    ovf_x, ovf_y, ovf_d;

  function automatic logic signed [CW-1:0] clip(input logic signed [SUM_W-1:0] v,
                                                output logic ovf);
    logic [SUM_W-CW:0] top;
    logic signed [CW-1:0] r;
    top = v[SUM_W-1:CW-1];
    ovf = !((&top) || !(|top));
    if (!ovf) begin
      r = v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    sum_x = SUM_W'(res_x_q);
    sum_y = SUM_W'(res_y_q);
    if (ctl5_q.side.add_org) begin
      sum_x = SUM_W'(res_x_q) + SUM_W'(ctl5_q.side.org_x);
      sum_y = SUM_W'(res_y_q) + SUM_W'(ctl5_q.side.org_y);
    end
    sat_x = clip(sum_x, ovf_x);
    sat_y = clip(sum_y, ovf_y);
    if (ctl5_q.side.zero_out) begin
      out_x_d = '0;
      out_y_d = '0;
      ovf_d   = 1'b0;
    end else begin
      out_x_d = sat_x;
      out_y_d = sat_y;
      ovf_d   = ovf_x || ovf_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
    end
  end

  logic signed [CW-1:0] out_x_q, out_y_q;
  logic                 ovf_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      mag_x_q  <= mag_x_d;
      mag_y_q  <= mag_y_d;
      sgn_x1_q <= x_i[RW-1];
      sgn_y1_q <= y_i[RW-1];
    end
    if (ctl1_q.valid) begin
      ph_x2_q  <= ph_x_d;
      ph_y2_q  <= ph_y_d;
      pl_x_q   <= pl_x_d;
      pl_y_q   <= pl_y_d;
      sgn_x2_q <= sgn_x1_q;
      sgn_y2_q <= sgn_y1_q;
    end
    if (ctl2_q.valid) begin
      lr_x_q   <= lsum_x[61:31];
      lr_y_q   <= lsum_y[61:31];
      ph_x3_q  <= ph_x2_q;
      ph_y3_q  <= ph_y2_q;
      sgn_x3_q <= sgn_x2_q;
      sgn_y3_q <= sgn_y2_q;
    end
    if (ctl3_q.valid) begin
      r_x_q    <= r_x_d;
      r_y_q    <= r_y_d;
      sgn_x4_q <= sgn_x3_q;
      sgn_y4_q <= sgn_y3_q;
    end
    if (ctl4_q.valid) begin
      res_x_q <= v_x[RW:G];
      res_y_q <= v_y[RW:G];
    end
    if (ctl5_q.valid) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      ovf_q   <= ovf_d;
    end
  end

  assign done_o     = ctl6_q.valid;
  assign out_x_o    = out_x_q;
  assign out_y_o    = out_y_q;
  assign overflow_o = ovf_q && ctl6_q.valid;

endmodule
